FILE: hw/rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types, lead byte thresholds and the lead byte decode shared by the
// six-byte UTF-8 stream decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 31;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned CONT_W  = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Lead byte class thresholds
  localparam byte_t LEAD2_MIN = 8'd128;
  localparam byte_t LEAD3_MIN = 8'd224;
  localparam byte_t LEAD4_MIN = 8'd240;
  localparam byte_t LEAD5_MIN = 8'd248;
  localparam byte_t LEAD6_MIN = 8'd252;

  // Continuation payload mask
  localparam byte_t CONT_MASK = 8'd63;

  localparam len_t LEN_ONE = 3'd1;

  typedef struct packed {
    len_t  len;
    byte_t payload;
  } lead_t;

  // Classify a lead byte: sequence length and its own payload bits
  function automatic lead_t lead_decode(input byte_t b);
    lead_t r;
    if (b < LEAD2_MIN) begin
      r.len     = 3'd1;
      r.payload = b;
    end else if (b >= LEAD6_MIN) begin
      r.len     = 3'd6;
      r.payload = b & 8'h01;
    end else if (b >= LEAD5_MIN) begin
      r.len     = 3'd5;
      r.payload = b & 8'h03;
    end else if (b >= LEAD4_MIN) begin
      r.len     = 3'd4;
      r.payload = b & 8'h07;
    end else if (b >= LEAD3_MIN) begin
      r.len     = 3'd3;
      r.payload = b & 8'h0F;
    end else begin
      r.len     = 3'd2;
      r.payload = b & 8'h1F;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/u8dec_byte_if.sv
// ----------------------------------------------------------------------------
// u8dec_byte_if
// Valid/ready channel carrying one raw byte of the text stream per item.
// ----------------------------------------------------------------------------
interface u8dec_byte_if;
  import u8dec_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hw/rtl/u8dec_cp_if.sv
// ----------------------------------------------------------------------------
// u8dec_cp_if
// Valid/ready channel carrying one decoded code point and its length per item.
// ----------------------------------------------------------------------------
interface u8dec_cp_if;
  import u8dec_pkg::*;

  logic valid;
  logic ready;
  cp_t  code_point;
  len_t seq_len;

  modport source (output valid, output code_point, output seq_len, input ready);
  modport sink   (input valid, input code_point, input seq_len, output ready);
endinterface

FILE: hw/rtl/utf8_stream_decoder.sv
// The decoder takes one byte per item and returns one item for every
// completed sequence of the original 1 to 6 byte UTF-8 form, carrying the
// code point and the number of bytes used; bytes inside a sequence return
// nothing. Unless the output stalls, the sustained rate is one byte per
// cycle, set by the single shift-and-merge update of the partial value
// register; a result appears in the cycle after its last byte is taken.
// Continuation bytes are not checked, and any byte seen while a sequence
// is open is merged as a continuation byte.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial six-byte UTF-8 decoder with a registered result stage.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic          clk,
  input  logic          rst_n,
  u8dec_byte_if.sink    in_ch,
  u8dec_cp_if.source    out_ch
);
  import u8dec_pkg::*;

  cp_t   partial_r, partial_nxt;
  len_t  left_r,    left_nxt;
  len_t  total_r,   total_nxt;
  logic  out_valid_r, out_valid_nxt;
  cp_t   out_cp_r,  out_cp_nxt;
  len_t  out_len_r, out_len_nxt;

  logic  take;
  lead_t lead;
  cp_t   merged;
  byte_t cont;

  // Accept while the result register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  assign lead   = lead_decode(in_ch.in_byte);
  assign cont   = in_ch.in_byte & CONT_MASK;
  assign merged = {partial_r[CP_W-CONT_W-1:0], cont[CONT_W-1:0]};

  // Decode one item and stage any finished code point
  always_comb begin
    partial_nxt   = partial_r;
    left_nxt      = left_r;
    total_nxt     = total_r;
    out_cp_nxt    = out_cp_r;
    out_len_nxt   = out_len_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (take) begin
      if (left_r == '0) begin
        if (lead.len == LEN_ONE) begin
          partial_nxt   = '0;
          total_nxt     = '0;
          out_cp_nxt    = cp_t'(in_ch.in_byte);
          out_len_nxt   = LEN_ONE;
          out_valid_nxt = 1'b1;
        end else begin
          partial_nxt = cp_t'(lead.payload);
          total_nxt   = lead.len;
          left_nxt    = lead.len - LEN_ONE;
        end
      end else begin
        left_nxt = left_r - LEN_ONE;
        if (left_r == LEN_ONE) begin
          partial_nxt   = '0;
          total_nxt     = '0;
          out_cp_nxt    = merged;
          out_len_nxt   = total_r;
          out_valid_nxt = 1'b1;
        end else begin
          partial_nxt = merged;
        end
      end
    end
  end

  // Hold decode state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      left_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      partial_r   <= partial_nxt;
      left_r      <= left_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cp_r  <= out_cp_nxt;
    out_len_r <= out_len_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = out_cp_r;
  assign out_ch.seq_len    = out_len_r;

endmodule
